// ----- rtl/core/lmps_pkg.sv -----
// ----------------------------------------------------------------------------
// Lamp mode pattern sequencer package
// Shared mode codes, register indexes, widths, bundle types and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lmps_pkg;

  // Width of the tick counter inside one pattern element.
  localparam int CNT_W = 8;
  localparam int CNT_MAX = (1 << CNT_W) - 1;

  // Pattern step width and pattern lengths.
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] SOS_STEPS = STEP_W'(19);
  localparam logic [STEP_W-1:0] SOS_WORD_STEP = STEP_W'(18);
  localparam logic [STEP_W-1:0] STROBE_STEPS = STEP_W'(2);
  localparam logic [STEP_W-1:0] FADE_LEVELS = STEP_W'(21);
  localparam logic [STEP_W-1:0] FADE_STEPS = STEP_W'(42);

  localparam logic [7:0] LEVEL_FULL = 8'd255;
  localparam logic [7:0] LEVEL_DARK = 8'd0;

  // Lamp modes, same encoding as the new_mode field.
  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_ON     = 3'd1,
    MODE_SOS    = 3'd2,
    MODE_STROBE = 3'd3,
    MODE_FADE   = 3'd4
  } mode_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_DOT        = 3'd1,
    REG_DASH       = 3'd2,
    REG_GAP        = 3'd3,
    REG_WORD_GAP   = 3'd4,
    REG_STROBE     = 3'd5,
    REG_FADE_STEP  = 3'd6
  } cfg_reg_t;

  // Item codes.
  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_SELECT = 1'b1;

  // Configuration seen by the sequencer: precomputed steady level and
  // raw duration registers.
  typedef struct packed {
    logic [7:0] on_level;
    logic [7:0] dot_units;
    logic [7:0] dash_units;
    logic [7:0] gap_units;
    logic [7:0] word_gap_units;
    logic [7:0] strobe_half_units;
    logic [7:0] fade_step_units;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [7:0] intensity;
    logic       lamp_lit;
    logic [2:0] active_mode;
  } res_t;

  // Duration register to element length in ticks: zero means one tick,
  // and values beyond the counter range saturate.
  function automatic logic [CNT_W-1:0] clamp_dur(input logic [7:0] d);
    logic [CNT_W-1:0] r;
    if (d == 8'd0) begin
      r = CNT_W'(1);
    end else if (32'(d) > CNT_MAX) begin
      r = CNT_W'(CNT_MAX);
    end else begin
      r = CNT_W'(d);
    end
    return r;
  endfunction

  // Number of pattern steps of a patterned mode.
  function automatic logic [STEP_W-1:0] step_count(input mode_t m);
    logic [STEP_W-1:0] r;
    unique case (m)
      MODE_SOS:    r = SOS_STEPS;
      MODE_STROBE: r = STROBE_STEPS;
      default:     r = FADE_STEPS;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lamp_mode_pattern_sequencer.sv -----
// ----------------------------------------------------------------------------
// Lamp mode pattern sequencer
// Tick and mode-select items in, one lamp intensity result out per item.
// ----------------------------------------------------------------------------
// Each accepted item (a time tick or a mode select) produces exactly one
// result: the lamp intensity, a lit flag and the running mode after that
// item. The state update and the level are computed combinationally from the
// pattern registers, and the result lands in an output register the next
// cycle, so the block accepts one item every cycle; input is stalled only
// while a finished result waits in the output register and the output side
// is stalled. Configuration registers are written through a plain write
// port; writing them only while no item is in flight is left to the user.
`default_nettype none

module lamp_mode_pattern_sequencer
  import lmps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 action,
  input  wire logic [2:0]           new_mode,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                intensity,
  output logic                      lamp_lit,
  output logic [2:0]                active_mode,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  cfg_t cfg;
  res_t result;
  logic accept;
  logic out_valid_next;

  // Input is taken whenever the output register is free or being emptied.
  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;

  lmps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lmps_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .action   (action),
    .new_mode (new_mode),
    .cfg      (cfg),
    .result   (result)
  );

  // Output valid flag.
  always_comb begin
    out_valid_next = out_valid;
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      intensity <= result.intensity;
      lamp_lit <= result.lamp_lit;
      active_mode <= result.active_mode;
    end
  end

`ifndef ASSERT_OFF
  // An accepted item always leaves a result behind.
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  // The lit flag follows the intensity.
  a_lit_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lamp_lit == (intensity != 8'd0)))
    else $error("lit flag disagrees with intensity");

  // A valid select shows the selected mode.
  a_select_mode: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_SELECT && new_mode <= MODE_FADE) |=>
      (active_mode == $past(new_mode)))
    else $error("select did not take effect");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/lmps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Lamp sequencer configuration registers
// Holds the duration registers and the precomputed steady-on lamp level.
// ----------------------------------------------------------------------------
`default_nettype none

module lmps_cfg_regs
  import lmps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  output cfg_t                      cfg
);

  logic [6:0]  pct_sat;
  logic [14:0] scaled;
  logic [27:0] recip;
  logic [7:0]  on_level_next;

  // Steady level is 255*p/100; divide by 100 via multiply by 5243 >> 19,
  // which is exact for numerators below 43690.
  always_comb begin
    pct_sat = (cfg_data[6:0] > 7'd100) ? 7'd100 : cfg_data[6:0];
    scaled = ({pct_sat, 8'd0}) - 15'(pct_sat);
    recip = 28'(scaled) * 28'd5243;
    on_level_next = recip[26:19];
  end

  // Register file with reset defaults.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_level <= 8'd204;
      cfg.dot_units <= 8'd4;
      cfg.dash_units <= 8'd12;
      cfg.gap_units <= 8'd4;
      cfg.word_gap_units <= 8'd16;
      cfg.strobe_half_units <= 8'd1;
      cfg.fade_step_units <= 8'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BRIGHTNESS: cfg.on_level <= on_level_next;
        REG_DOT:        cfg.dot_units <= cfg_data;
        REG_DASH:       cfg.dash_units <= cfg_data;
        REG_GAP:        cfg.gap_units <= cfg_data;
        REG_WORD_GAP:   cfg.word_gap_units <= cfg_data;
        REG_STROBE:     cfg.strobe_half_units <= cfg_data;
        REG_FADE_STEP:  cfg.fade_step_units <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lmps_seq.sv -----
// ----------------------------------------------------------------------------
// Lamp sequencer pattern state
// Mode, pattern step and tick counter with their single-pass update, and
// the lamp level that follows from the updated state.
// ----------------------------------------------------------------------------
`default_nettype none

module lmps_seq
  import lmps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic       action,
  input  wire logic [2:0] new_mode,
  input  cfg_t            cfg,
  output res_t            result
);

  mode_t             current_mode;
  mode_t             current_mode_next;
  logic [STEP_W-1:0] pattern_step;
  logic [STEP_W-1:0] pattern_step_next;
  logic [CNT_W-1:0]  unit_count;
  logic [CNT_W-1:0]  unit_count_next;

  logic [STEP_W-1:0] n_steps;
  logic [STEP_W-1:0] ps;
  logic [STEP_W-1:0] ps_inc;
  logic [STEP_W-2:0] flash_idx;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  elem_len;
  logic              patterned;
  logic [4:0]        fade_k;
  logic [9:0]        fade_prod;
  logic [7:0]        level;

  assign patterned = (current_mode == MODE_SOS) || (current_mode == MODE_STROBE) ||
                     (current_mode == MODE_FADE);

  // Length of the current pattern element in ticks.
  always_comb begin
    n_steps = step_count(current_mode);
    ps = (pattern_step >= n_steps) ? '0 : pattern_step;
    flash_idx = ps[STEP_W-1:1];
    unique case (current_mode)
      MODE_SOS: begin
        if (ps >= SOS_WORD_STEP) begin
          elem_len = clamp_dur(cfg.word_gap_units);
        end else if (ps[0]) begin
          elem_len = clamp_dur(cfg.gap_units);
        end else if (flash_idx >= (STEP_W-1)'(3) && flash_idx <= (STEP_W-1)'(5)) begin
          elem_len = clamp_dur(cfg.dash_units);
        end else begin
          elem_len = clamp_dur(cfg.dot_units);
        end
      end
      MODE_STROBE: elem_len = clamp_dur(cfg.strobe_half_units);
      default:     elem_len = clamp_dur(cfg.fade_step_units);
    endcase
  end

  // Next state: known selects restart, ticks step a running pattern.
  always_comb begin
    current_mode_next = current_mode;
    pattern_step_next = pattern_step;
    unit_count_next = unit_count;
    cnt_inc = unit_count + CNT_W'(1);
    ps_inc = ps + STEP_W'(1);
    if (action == ACT_SELECT) begin
      if (new_mode <= MODE_FADE) begin
        current_mode_next = mode_t'(new_mode);
        pattern_step_next = '0;
        unit_count_next = '0;
      end
    end else if (patterned) begin
      if (cnt_inc >= elem_len) begin
        unit_count_next = '0;
        pattern_step_next = (ps_inc >= n_steps) ? '0 : ps_inc;
      end else begin
        unit_count_next = cnt_inc;
        pattern_step_next = ps;
      end
    end
  end

  // Fade level: 255*(5k)/100 equals 51k/4 rounded down.
  always_comb begin
    if (pattern_step_next < FADE_LEVELS) begin
      fade_k = pattern_step_next[4:0];
    end else if (pattern_step_next < FADE_STEPS) begin
      fade_k = 5'(FADE_STEPS - STEP_W'(1) - pattern_step_next);
    end else begin
      fade_k = 5'd20;
    end
    fade_prod = 10'(fade_k) * 10'd51;
  end

  // Lamp level of the updated state.
  always_comb begin
    unique case (current_mode_next)
      MODE_ON:     level = cfg.on_level;
      MODE_SOS:    level = (pattern_step_next < SOS_WORD_STEP && !pattern_step_next[0]) ?
                           LEVEL_FULL : LEVEL_DARK;
      MODE_STROBE: level = (pattern_step_next == '0) ? LEVEL_FULL : LEVEL_DARK;
      MODE_FADE:   level = (fade_prod[9:2] == 8'd0) ? LEVEL_DARK : fade_prod[9:2];
      default:     level = LEVEL_DARK;
    endcase
    result.intensity = level;
    result.lamp_lit = (level != LEVEL_DARK);
    result.active_mode = current_mode_next;
  end

  // State registers, updated once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode <= MODE_OFF;
      pattern_step <= '0;
      unit_count <= '0;
    end else if (accept) begin
      current_mode <= current_mode_next;
      pattern_step <= pattern_step_next;
      unit_count <= unit_count_next;
    end
  end

`ifndef ASSERT_OFF
  // The step stays inside the running pattern.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    patterned |-> pattern_step < step_count(current_mode))
    else $error("pattern step beyond pattern length");

  // Steady modes keep the pattern state cleared.
  a_steady_clear: assert property (@(posedge clk) disable iff (rst)
    (current_mode == MODE_OFF || current_mode == MODE_ON) |->
      (pattern_step == '0 && unit_count == '0))
    else $error("steady mode with pattern state");

  // A tick never changes the mode.
  a_tick_keeps_mode: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_TICK) |=> $stable(current_mode))
    else $error("tick changed the mode");
`endif

endmodule

`default_nettype wire

// ----- sim/lamp_level_checker.sv -----
// ----------------------------------------------------------------------------
// Lamp level checker
// Watches the item and result channels of the lamp mode pattern sequencer,
// follows the register writes, predicts the lamp result of every accepted
// item and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module lamp_level_checker
  import lmps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 action,
  input  logic [2:0]           new_mode,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [7:0]           intensity,
  input  logic                 lamp_lit,
  input  logic [2:0]           active_mode,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   pending,
  output int                   mismatches,
  output int                   checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register values after reset.
  localparam logic [6:0] BRIGHT_AT_RESET   = 7'd80;
  localparam logic [7:0] DOT_AT_RESET      = 8'd4;
  localparam logic [7:0] DASH_AT_RESET     = 8'd12;
  localparam logic [7:0] GAP_AT_RESET      = 8'd4;
  localparam logic [7:0] WORD_GAP_AT_RESET = 8'd16;
  localparam logic [7:0] STROBE_AT_RESET   = 8'd1;
  localparam logic [7:0] FADE_AT_RESET     = 8'd1;

  // The fourth to sixth flashes of an SOS group are the long ones.
  localparam int FIRST_DASH = 3;
  localparam int LAST_DASH  = 5;

  // Local copy of the registers.
  logic [6:0] bright_pct;
  logic [7:0] dot_len;
  logic [7:0] dash_len;
  logic [7:0] gap_len;
  logic [7:0] word_gap_len;
  logic [7:0] strobe_len;
  logic [7:0] fade_len;

  // Local copy of the pattern state.
  mode_t             lamp_mode;
  logic [STEP_W-1:0] lamp_step;
  logic [CNT_W-1:0]  lamp_ticks;

  // Predicted results still waiting for the output side.
  res_t lamp_q[$];

  // A zero length lasts one tick; lengths beyond the counter saturate.
  function automatic logic [CNT_W-1:0] hold_ticks(input logic [7:0] len);
    logic [CNT_W-1:0] t;
    if (len == 8'd0) begin
      t = CNT_W'(1);
    end else if (int'(len) > CNT_MAX) begin
      t = CNT_W'(CNT_MAX);
    end else begin
      t = CNT_W'(len);
    end
    return t;
  endfunction

  // Number of ticks the current pattern element lasts.
  function automatic logic [CNT_W-1:0] element_ticks();
    logic [7:0] len;
    int         flash;
    flash = int'(lamp_step) / 2;
    if (lamp_mode == MODE_SOS) begin
      if (lamp_step >= SOS_WORD_STEP) begin
        len = word_gap_len;
      end else if (lamp_step[0]) begin
        len = gap_len;
      end else if (flash >= FIRST_DASH && flash <= LAST_DASH) begin
        len = dash_len;
      end else begin
        len = dot_len;
      end
    end else if (lamp_mode == MODE_STROBE) begin
      len = strobe_len;
    end else begin
      len = fade_len;
    end
    return hold_ticks(len);
  endfunction

  function automatic logic [STEP_W-1:0] pattern_len(input mode_t m);
    logic [STEP_W-1:0] n;
    if (m == MODE_SOS) begin
      n = SOS_STEPS;
    end else if (m == MODE_STROBE) begin
      n = STROBE_STEPS;
    end else begin
      n = FADE_STEPS;
    end
    return n;
  endfunction

  // Lamp level shown for the current mode and pattern step.
  function automatic logic [7:0] lamp_level();
    int         pct;
    logic [7:0] lvl;
    case (lamp_mode)
      MODE_ON: begin
        pct = (bright_pct > 7'd100) ? 100 : int'(bright_pct);
        lvl = 8'(255 * pct / 100);
      end
      MODE_SOS: begin
        lvl = (lamp_step < SOS_WORD_STEP && !lamp_step[0]) ? LEVEL_FULL : LEVEL_DARK;
      end
      MODE_STROBE: begin
        lvl = (lamp_step == '0) ? LEVEL_FULL : LEVEL_DARK;
      end
      MODE_FADE: begin
        if (lamp_step < FADE_LEVELS) begin
          pct = int'(lamp_step) * 5;
        end else begin
          pct = (int'(FADE_STEPS) - 1 - int'(lamp_step)) * 5;
        end
        if (pct > 100) begin
          pct = 100;
        end
        lvl = 8'(255 * pct / 100);
      end
      default: begin
        lvl = LEVEL_DARK;
      end
    endcase
    return lvl;
  endfunction

  // Apply one item to the pattern state and return the lamp result.
  task automatic advance_lamp(input logic act, input logic [2:0] sel, output res_t r);
    logic [STEP_W-1:0] nsteps;
    logic [7:0]        lvl;
    if (act == ACT_SELECT) begin
      // Unknown mode codes leave mode and pattern alone.
      if (sel <= MODE_FADE) begin
        lamp_mode  = mode_t'(sel);
        lamp_step  = '0;
        lamp_ticks = '0;
      end
    end else if (lamp_mode == MODE_SOS || lamp_mode == MODE_STROBE ||
                 lamp_mode == MODE_FADE) begin
      nsteps = pattern_len(lamp_mode);
      if (lamp_step >= nsteps) begin
        lamp_step = '0;
      end
      lamp_ticks = lamp_ticks + CNT_W'(1);
      if (lamp_ticks >= element_ticks()) begin
        lamp_ticks = '0;
        lamp_step  = (lamp_step + STEP_W'(1) >= nsteps) ? '0 : lamp_step + STEP_W'(1);
      end
    end
    lvl           = lamp_level();
    r.intensity   = lvl;
    r.lamp_lit    = (lvl != LEVEL_DARK);
    r.active_mode = lamp_mode;
  endtask

  task automatic note_mismatch(input string what, input int want_v, input int got_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] lamp result %0d: %s expected %0d, got %0d",
               $realtime, checked, what, want_v, got_v);
    end
  endtask

  // Follow register writes, check results, then predict the new item.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      bright_pct   = BRIGHT_AT_RESET;
      dot_len      = DOT_AT_RESET;
      dash_len     = DASH_AT_RESET;
      gap_len      = GAP_AT_RESET;
      word_gap_len = WORD_GAP_AT_RESET;
      strobe_len   = STROBE_AT_RESET;
      fade_len     = FADE_AT_RESET;
      lamp_mode    = MODE_OFF;
      lamp_step    = '0;
      lamp_ticks   = '0;
      lamp_q.delete();
      mismatches   = 0;
      checked      = 0;
      pending     <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_BRIGHTNESS: bright_pct   = cfg_data[6:0];
          REG_DOT:        dot_len      = cfg_data;
          REG_DASH:       dash_len     = cfg_data;
          REG_GAP:        gap_len      = cfg_data;
          REG_WORD_GAP:   word_gap_len = cfg_data;
          REG_STROBE:     strobe_len   = cfg_data;
          REG_FADE_STEP:  fade_len     = cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (lamp_q.size() == 0) begin
          note_mismatch("unexpected result, intensity", -1, int'(intensity));
        end else begin
          want = lamp_q.pop_front();
          if (intensity !== want.intensity) begin
            note_mismatch("intensity", int'(want.intensity), int'(intensity));
          end
          if (lamp_lit !== want.lamp_lit) begin
            note_mismatch("lamp_lit", int'(want.lamp_lit), int'(lamp_lit));
          end
          if (active_mode !== want.active_mode) begin
            note_mismatch("active_mode", int'(want.active_mode), int'(active_mode));
          end
        end
        checked++;
      end

      if (in_valid && !in_stall) begin
        advance_lamp(action, new_mode, want);
        lamp_q.push_back(want);
      end
      pending <= lamp_q.size();
    end
  end

endmodule

// ----- sim/lamp_mode_pattern_sequencer_tb.sv -----
// ----------------------------------------------------------------------------
// Lamp mode pattern sequencer testbench
// Drives tick and mode-select items with random gaps and output stalls over
// a series of register settings; a checker beside the block predicts and
// compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module lamp_mode_pattern_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lmps_pkg::*;

  localparam int ITEM_TARGET = 1900;
  localparam int PHASE_ITEMS = 170;
  localparam int QUIET_LIMIT = 1000;

  // Select codes that name no mode.
  localparam logic [2:0] SEL_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0] SEL_UNKNOWN_LAST  = 3'd7;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 action;
  logic [2:0]           new_mode;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           intensity;
  logic                 lamp_lit;
  logic [2:0]           active_mode;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  int pending;
  int mismatches;
  int checked;

  bit burst;
  int quiet_cycles;
  int selects_sent;
  int ticks_sent;
  int settings_used;
  int busy_items;

  lamp_mode_pattern_sequencer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .new_mode    (new_mode),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .intensity   (intensity),
    .lamp_lit    (lamp_lit),
    .active_mode (active_mode),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  lamp_level_checker lamp_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .new_mode    (new_mode),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .intensity   (intensity),
    .lamp_lit    (lamp_lit),
    .active_mode (active_mode),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pending     (pending),
    .mismatches  (mismatches),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      n = 0;
    end else if (r < 90) begin
      n = $urandom_range(1, 3);
    end else if (r < 97) begin
      n = $urandom_range(4, 12);
    end else begin
      n = $urandom_range(20, 60);
    end
    return n;
  endfunction

  // Durations: mostly short, sometimes zero or the largest value.
  function automatic logic [7:0] pick_len();
    int         r;
    logic [7:0] v;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      v = 8'd0;
    end else if (r == 1) begin
      v = 8'd255;
    end else if (r < 6) begin
      v = 8'($urandom_range(4, 10));
    end else begin
      v = 8'($urandom_range(1, 3));
    end
    return v;
  endfunction

  function automatic logic [7:0] pick_bright();
    int         r;
    logic [7:0] v;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      v = 8'd0;
    end else if (r == 1) begin
      v = 8'd100;
    end else if (r == 2) begin
      v = 8'd127;
    end else begin
      v = 8'($urandom_range(0, 127));
    end
    return v;
  endfunction

  // Present one item after a random gap and hold it until it is taken.
  task automatic send_item(input logic act, input logic [2:0] sel);
    int gap;
    gap = burst ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    new_mode <= sel;
    do @(posedge clk); while (in_stall);
    if (act == ACT_SELECT) begin
      selects_sent++;
    end else begin
      ticks_sent++;
    end
  endtask

  // The mode field is ignored on a tick, so it carries random bits.
  task automatic send_tick();
    send_item(ACT_TICK, 3'($urandom_range(0, SEL_UNKNOWN_LAST)));
  endtask

  // Stop sending and wait until every result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Back-to-back writes of all seven registers, then release the port.
  task automatic program_regs(input logic [7:0] bright, input logic [7:0] dot,
                              input logic [7:0] dash, input logic [7:0] gap,
                              input logic [7:0] word_gap, input logic [7:0] strobe,
                              input logic [7:0] fade);
    write_reg(REG_BRIGHTNESS, bright);
    write_reg(REG_DOT, dot);
    write_reg(REG_DASH, dash);
    write_reg(REG_GAP, gap);
    write_reg(REG_WORD_GAP, word_gap);
    write_reg(REG_STROBE, strobe);
    write_reg(REG_FADE_STEP, fade);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Mostly a mode select followed by a run of ticks; the rest is noise.
  task automatic random_phase();
    int    got;
    int    r;
    int    run;
    mode_t m;
    got = 0;
    while (got < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        m = mode_t'($urandom_range(MODE_OFF, MODE_FADE));
        send_item(ACT_SELECT, m);
        got++;
        if (m == MODE_OFF || m == MODE_ON) begin
          run = $urandom_range(0, 3);
        end else begin
          run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 220) : $urandom_range(1, 40);
          got += run;
        end
        repeat (run) send_tick();
      end else if (r < 90) begin
        send_item(ACT_SELECT, 3'($urandom_range(SEL_UNKNOWN_FIRST, SEL_UNKNOWN_LAST)));
      end else begin
        send_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, SEL_UNKNOWN_LAST)));
      end
    end
    busy_items += got;
  endtask

  // Output side: random stall bursts, none while a burst phase runs.
  initial begin
    int hold;
    forever begin
      hold = burst ? 0 : idle_len();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out after %0d cycles with no item moving.", quiet_cycles);
      $display("** lamp_mode_pattern_sequencer: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    int phase;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    action    <= ACT_TICK;
    new_mode  <= MODE_OFF;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_BRIGHTNESS;
    cfg_data  <= 8'd0;
    burst      = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: every mode, ticks in off and on, unknown selects.
    send_tick();
    send_item(ACT_SELECT, MODE_OFF);
    send_item(ACT_SELECT, MODE_ON);
    send_tick();
    send_item(ACT_SELECT, SEL_UNKNOWN_FIRST);
    send_item(ACT_SELECT, SEL_UNKNOWN_LAST);
    send_item(ACT_SELECT, MODE_SOS);
    repeat (4) send_tick();
    send_item(ACT_SELECT, MODE_STROBE);
    repeat (2) send_tick();
    send_item(ACT_SELECT, MODE_FADE);
    repeat (2) send_tick();

    // Brightness above 100 and zero lengths, starting from inside a fade.
    settle();
    program_regs(8'd127, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_tick();
    send_item(ACT_SELECT, MODE_STROBE);
    send_tick();
    send_item(ACT_SELECT, MODE_ON);

    // Brightness changed while the lamp is steadily on, longest lengths.
    settle();
    program_regs(8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_tick();
    send_item(ACT_SELECT, SEL_UNKNOWN_FIRST);

    // Random phases, each under its own register setting.
    phase = 0;
    while (busy_items < ITEM_TARGET) begin
      settle();
      case (phase)
        0: program_regs(8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
        1: program_regs(8'd127, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        2: program_regs(8'd100, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        default: program_regs(pick_bright(), pick_len(), pick_len(), pick_len(),
                              pick_len(), pick_len(), pick_len());
      endcase
      burst = (phase % 4 == 3);
      random_phase();
      phase++;
    end

    burst = 1'b0;
    settle();
    repeat (4) @(posedge clk);

    $display("Sent %0d mode selects and %0d ticks under %0d register settings;",
             selects_sent, ticks_sent, settings_used);
    $display("%0d lamp results checked, %0d field mismatches.", checked, mismatches);
    if (mismatches == 0) begin
      $display("** lamp_mode_pattern_sequencer: PASSED **");
    end else begin
      $display("** lamp_mode_pattern_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

// ----- lamp_mode_pattern_sequencer.f -----
rtl/core/lmps_pkg.sv
rtl/core/lmps_cfg_regs.sv
rtl/core/lmps_seq.sv
rtl/core/lamp_mode_pattern_sequencer.sv
sim/lamp_level_checker.sv
sim/lamp_mode_pattern_sequencer_tb.sv
